FILE: hdl/sem_pkg.sv
// ----------------------------------------------------------------------------
// sem_pkg
// Shared types, constants and kernel tables for the RGB Sobel magnitude block.
// ----------------------------------------------------------------------------
package sem_pkg;

  localparam int MAX_WIDTH_DEF = 1024;

  localparam int CH_N  = 3;
  localparam int CH_W  = 8;
  localparam int PIX_W = CH_N * CH_W;

  localparam int FW_W   = 11;
  localparam int FH_W   = 16;
  localparam int ROW_W  = 17;
  localparam int FW_RST = 1024;
  localparam int FH_RST = 768;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam int G_W   = 11;
  localparam int SQ_W  = 21;
  localparam int SAT_W = 16;
  localparam logic [SQ_W-1:0] SAT_LIM = SQ_W'(65280);

  localparam int ROOT_W   = 8;
  localparam int ROOT_STG = 4;
  localparam int ROOT_BPS = 2;
  localparam int REM_W    = 17;
  localparam logic [ROOT_W-1:0] ROOT_MAX = ROOT_W'(255);

  typedef logic signed [2:0] kern_t;

  localparam kern_t KERN_X [9] = '{-3'sd1, 3'sd0, 3'sd1,
                                   -3'sd2, 3'sd0, 3'sd2,
                                   -3'sd1, 3'sd0, 3'sd1};
  localparam kern_t KERN_Y [9] = '{-3'sd1, -3'sd2, -3'sd1,
                                    3'sd0,  3'sd0,  3'sd0,
                                    3'sd1,  3'sd2,  3'sd1};

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic            op;
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;
  } sem_in_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic            frame_last;
  } sem_out_t;

  // 3x3 neighborhood of one centre pixel; px[row][col], row 0 on top
  typedef struct packed {
    logic                 vld;
    logic                 last;
    logic [2:0]           row_ok;
    logic [2:0]           col_ok;
    pix_t [2:0][2:0]      px;
  } sem_win_t;

  typedef struct packed {
    logic                      vld;
    logic                      last;
    logic [CH_N-1:0][SQ_W-1:0] sq;
  } sem_sq_t;

  typedef struct packed {
    logic     vld;
    sem_out_t data;
  } sem_res_t;

endpackage

FILE: hdl/sem_front.sv
// ----------------------------------------------------------------------------
// sem_front
// Frame position counters, two-row line store memory with write forwarding,
// and the sliding column window feeding the gradient stage.
// ----------------------------------------------------------------------------
module sem_front #(
  parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            in_valid_i,
  input  sem_pkg::sem_in_t                in_data_i,
  input  logic                            cfg_we_i,
  input  logic [sem_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sem_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output sem_pkg::sem_win_t               win_o
);

  localparam int CW      = $clog2(MAX_WIDTH);
  localparam int ENT_W   = 2 * sem_pkg::PIX_W;
  localparam int WM1_RST = (sem_pkg::FW_RST > MAX_WIDTH) ? MAX_WIDTH - 1
                                                         : sem_pkg::FW_RST - 1;
  localparam int HM1_RST = sem_pkg::FH_RST - 1;

  logic [CW-1:0]                 wm1_q, wm1_d;
  logic [sem_pkg::FH_W-1:0]      hm1_q, hm1_d;
  logic [CW-1:0]                 col_q, col_d;
  logic [sem_pkg::ROW_W-1:0]     row_q, row_d;

  logic                          acc;
  logic                          first;
  logic                          has_row;
  logic [sem_pkg::ROW_W-1:0]     rc;
  logic [sem_pkg::ROW_W-1:0]     hm1_ext;
  logic [CW-1:0]                 cc;
  logic                          res;
  logic                          last;
  logic                          wrap;
  logic [2:0]                    row_ok;
  logic [2:0]                    col_ok;
  sem_pkg::pix_t                 pix;

  logic                          s1_vld_q;
  logic                          s1_res_q;
  logic                          s1_first_q;
  logic                          s1_last_q;
  logic [2:0]                    s1_row_ok_q;
  logic [2:0]                    s1_col_ok_q;
  logic [CW-1:0]                 s1_addr_q;
  sem_pkg::pix_t                 s1_pix_q;

  logic                          fwd_vld_q;
  logic [CW-1:0]                 fwd_addr_q;
  logic [ENT_W-1:0]              fwd_data_q;

  logic [ENT_W-1:0]              mem_q [MAX_WIDTH];
  logic [ENT_W-1:0]              rdata_q;
  logic [ENT_W-1:0]              ent;
  logic [ENT_W-1:0]              wr_data;
  logic                          wr_en;
  sem_pkg::pix_t                 top;
  sem_pkg::pix_t                 mid;

  sem_pkg::pix_t [2:0]           col_a_q;
  sem_pkg::pix_t [2:0]           col_b_q;
  sem_pkg::pix_t [2:0]           col_new;

  // effective width and height, stored minus one
  always_comb begin
    wm1_d = wm1_q;
    hm1_d = hm1_q;
    if (cfg_we_i && cfg_idx_i == sem_pkg::REG_FRAME_WIDTH) begin
      if (cfg_wdata_i[sem_pkg::FW_W-1:0] == '0) begin
        wm1_d = '0;
      end else if (32'(cfg_wdata_i[sem_pkg::FW_W-1:0]) > 32'(MAX_WIDTH)) begin
        wm1_d = CW'(MAX_WIDTH - 1);
      end else begin
        wm1_d = CW'(cfg_wdata_i[sem_pkg::FW_W-1:0] - sem_pkg::FW_W'(1));
      end
    end
    if (cfg_we_i && cfg_idx_i == sem_pkg::REG_FRAME_HEIGHT) begin
      if (cfg_wdata_i[sem_pkg::FH_W-1:0] == '0) begin
        hm1_d = '0;
      end else begin
        hm1_d = cfg_wdata_i[sem_pkg::FH_W-1:0] - sem_pkg::FH_W'(1);
      end
    end
  end

  // centre position of the word being accepted
  always_comb begin
    acc     = in_valid_i && en_i;
    hm1_ext = sem_pkg::ROW_W'(hm1_q);
    first   = (col_q == '0);
    has_row = first ? (row_q >= sem_pkg::ROW_W'(2)) : (row_q != '0);
    rc      = row_q - (first ? sem_pkg::ROW_W'(2) : sem_pkg::ROW_W'(1));
    cc      = first ? wm1_q : col_q - CW'(1);
    res     = has_row && (rc <= hm1_ext);
    row_ok  = {rc != hm1_ext, 1'b1, rc != '0};
    col_ok  = {cc != wm1_q, 1'b1, cc != '0};
    last    = res && (rc == hm1_ext) && (cc == wm1_q);
    wrap    = (col_q == wm1_q);
    pix     = (in_data_i.op == sem_pkg::OP_FLUSH) ? '0
            : {in_data_i.in_red, in_data_i.in_green, in_data_i.in_blue};
    if (last) begin
      col_d = '0;
      row_d = '0;
    end else if (wrap) begin
      col_d = '0;
      row_d = row_q + sem_pkg::ROW_W'(1);
    end else begin
      col_d = col_q + CW'(1);
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wm1_q <= CW'(WM1_RST);
      hm1_q <= sem_pkg::FH_W'(HM1_RST);
      col_q <= '0;
      row_q <= '0;
    end else begin
      wm1_q <= wm1_d;
      hm1_q <= hm1_d;
      if (cfg_we_i) begin
        col_q <= '0;
        row_q <= '0;
      end else if (acc) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  // line store: read at accept, written back from the registered stage-one word
  always_comb begin
    wr_en   = en_i && s1_vld_q;
    ent     = (fwd_vld_q && fwd_addr_q == s1_addr_q) ? fwd_data_q : rdata_q;
    top     = ent[ENT_W-1:sem_pkg::PIX_W];
    mid     = ent[sem_pkg::PIX_W-1:0];
    wr_data = {mid, s1_pix_q};
    col_new = {s1_pix_q, mid, top};
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[s1_addr_q] <= wr_data;
    end
    if (acc) begin
      rdata_q <= mem_q[col_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s1_res_q  <= 1'b0;
      fwd_vld_q <= 1'b0;
    end else if (en_i) begin
      s1_vld_q  <= in_valid_i;
      s1_res_q  <= in_valid_i && res;
      // read and write of consecutive words hit the same edge
      fwd_vld_q <= s1_vld_q && in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_first_q  <= first;
      s1_last_q   <= last;
      s1_row_ok_q <= row_ok;
      s1_col_ok_q <= col_ok;
      s1_addr_q   <= col_q;
      s1_pix_q    <= pix;
    end
    if (en_i) begin
      fwd_addr_q <= s1_addr_q;
      fwd_data_q <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_a_q <= '0;
      col_b_q <= '0;
    end else if (wr_en) begin
      col_a_q <= col_b_q;
      col_b_q <= col_new;
    end
  end

  always_comb begin
    win_o.vld    = s1_res_q;
    win_o.last   = s1_last_q;
    win_o.row_ok = s1_row_ok_q;
    win_o.col_ok = s1_col_ok_q;
    for (int i = 0; i < 3; i++) begin
      win_o.px[i][0] = col_a_q[i];
      win_o.px[i][1] = col_b_q[i];
      win_o.px[i][2] = s1_first_q ? '0 : col_new[i];
    end
  end

endmodule

FILE: hdl/sem_grad.sv
// ----------------------------------------------------------------------------
// sem_grad
// Masked Sobel Gx/Gy sums per channel, then the squared gradient magnitude.
// ----------------------------------------------------------------------------
module sem_grad (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  sem_pkg::sem_win_t  win_i,
  output sem_pkg::sem_sq_t   sq_o
);

  localparam int P_W = 2 * sem_pkg::G_W;

  logic signed [sem_pkg::G_W-1:0]  gx [sem_pkg::CH_N];
  logic signed [sem_pkg::G_W-1:0]  gy [sem_pkg::CH_N];
  logic signed [sem_pkg::G_W-1:0]  gx_q [sem_pkg::CH_N];
  logic signed [sem_pkg::G_W-1:0]  gy_q [sem_pkg::CH_N];
  logic                            g_vld_q;
  logic                            g_last_q;

  logic [sem_pkg::CH_N-1:0][sem_pkg::SQ_W-1:0] sq;
  logic [sem_pkg::CH_N-1:0][sem_pkg::SQ_W-1:0] sq_q;
  logic                                        q_vld_q;
  logic                                        q_last_q;

  always_comb begin
    logic [sem_pkg::CH_W-1:0]       v;
    logic signed [sem_pkg::G_W-1:0] ve;
    for (int ch = 0; ch < sem_pkg::CH_N; ch++) begin
      gx[ch] = '0;
      gy[ch] = '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          v  = (win_i.row_ok[i] && win_i.col_ok[j])
             ? win_i.px[i][j][ch*sem_pkg::CH_W +: sem_pkg::CH_W] : '0;
          ve = $signed(sem_pkg::G_W'(v));
          gx[ch] = gx[ch] + ve * sem_pkg::G_W'(sem_pkg::KERN_X[i*3+j]);
          gy[ch] = gy[ch] + ve * sem_pkg::G_W'(sem_pkg::KERN_Y[i*3+j]);
        end
      end
    end
  end

  always_comb begin
    logic signed [P_W-1:0] gxe;
    logic signed [P_W-1:0] gye;
    logic signed [P_W-1:0] s;
    for (int ch = 0; ch < sem_pkg::CH_N; ch++) begin
      gxe    = P_W'(gx_q[ch]);
      gye    = P_W'(gy_q[ch]);
      s      = gxe * gxe + gye * gye;
      sq[ch] = sem_pkg::SQ_W'(s);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_vld_q <= 1'b0;
      q_vld_q <= 1'b0;
    end else if (en_i) begin
      g_vld_q <= win_i.vld;
      q_vld_q <= g_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      g_last_q <= win_i.last;
      q_last_q <= g_last_q;
      gx_q     <= gx;
      gy_q     <= gy;
      sq_q     <= sq;
    end
  end

  assign sq_o = '{vld: q_vld_q, last: q_last_q, sq: sq_q};

endmodule

FILE: hdl/sem_root.sv
// ----------------------------------------------------------------------------
// sem_root
// Pipelined digit-by-digit square root per channel, rounded and clamped.
// ----------------------------------------------------------------------------
module sem_root (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  sem_pkg::sem_sq_t   sq_i,
  output sem_pkg::sem_res_t  res_o
);

  localparam int NSTG  = sem_pkg::ROOT_STG;
  localparam int SUB_W = sem_pkg::REM_W + 1;

  typedef struct packed {
    logic                        big;
    logic [sem_pkg::REM_W-1:0]   rem;
    logic [sem_pkg::ROOT_W-1:0]  root;
  } rt_t;

  // one result bit: rem holds s - root^2
  function automatic rt_t rt_step(rt_t x, int b);
    rt_t              y;
    logic [SUB_W-1:0] sub;
    y   = x;
    sub = (SUB_W'(x.root) << (b + 1)) + (SUB_W'(1) << (2 * b));
    if ({1'b0, x.rem} >= sub) begin
      y.rem  = sem_pkg::REM_W'({1'b0, x.rem} - sub);
      y.root = x.root | (sem_pkg::ROOT_W'(1) << b);
    end
    return y;
  endfunction

  logic [NSTG-1:0]                vld_q;
  logic [NSTG-1:0]                last_q;
  rt_t [sem_pkg::CH_N-1:0]        st_in [NSTG];
  rt_t [sem_pkg::CH_N-1:0]        st_d  [NSTG];
  rt_t [sem_pkg::CH_N-1:0]        st_q  [NSTG];
  logic [sem_pkg::ROOT_W-1:0]     val [sem_pkg::CH_N];

  always_comb begin
    rt_t cur;
    for (int ch = 0; ch < sem_pkg::CH_N; ch++) begin
      st_in[0][ch].big  = sq_i.sq[ch] > sem_pkg::SAT_LIM;
      st_in[0][ch].rem  = sem_pkg::REM_W'(sq_i.sq[ch][sem_pkg::SAT_W-1:0]);
      st_in[0][ch].root = '0;
    end
    for (int k = 1; k < NSTG; k++) begin
      st_in[k] = st_q[k-1];
    end
    for (int k = 0; k < NSTG; k++) begin
      for (int ch = 0; ch < sem_pkg::CH_N; ch++) begin
        cur = st_in[k][ch];
        for (int j = 0; j < sem_pkg::ROOT_BPS; j++) begin
          cur = rt_step(cur, sem_pkg::ROOT_W - 1 - (k * sem_pkg::ROOT_BPS + j));
        end
        st_d[k][ch] = cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NSTG-2:0], sq_i.vld};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      last_q <= {last_q[NSTG-2:0], sq_i.last};
      for (int k = 0; k < NSTG; k++) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  always_comb begin
    rt_t fin;
    for (int ch = 0; ch < sem_pkg::CH_N; ch++) begin
      fin = st_q[NSTG-1][ch];
      if (fin.big) begin
        val[ch] = sem_pkg::ROOT_MAX;
      end else if (fin.rem > sem_pkg::REM_W'(fin.root)) begin
        val[ch] = fin.root + sem_pkg::ROOT_W'(1);
      end else begin
        val[ch] = fin.root;
      end
    end
    res_o.vld             = vld_q[NSTG-1];
    res_o.data.out_red    = val[2];
    res_o.data.out_green  = val[1];
    res_o.data.out_blue   = val[0];
    res_o.data.frame_last = last_q[NSTG-1];
  end

endmodule

FILE: hdl/sobel_edge_magnitude_rgb.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb
// Takes one RGB word per clock while not stalled, in raster order, and returns
// per channel the rounded Sobel magnitude clamped to 255, with zero outside the
// frame. A result belongs to the pixel one row and one column behind the latest
// input; after a frame the host sends frame_width+1 flush words to drain the
// last row, and the bottom right result carries frame_last. Inside the block a
// result passes through the line store read register, the gradient and square
// registers, the root pipeline stages and the output register. The line
// store is a single memory of MAX_WIDTH entries with one read and one write
// per cycle; back to back accesses to the same entry (a one pixel wide frame)
// are forwarded. With the output taken every cycle the block accepts one word
// per clock; a stalled output freezes the whole pipeline. No clearing pass after
// reset. Writing either register restarts the frame at the top left pixel.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_rgb #(
  parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  sem_pkg::sem_in_t                in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output sem_pkg::sem_out_t               out_data_o,
  input  logic                            cfg_we_i,
  input  logic [sem_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sem_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  logic               en;
  sem_pkg::sem_win_t  win;
  sem_pkg::sem_sq_t   sq;
  sem_pkg::sem_res_t  res;
  logic               out_vld_q;
  sem_pkg::sem_out_t  out_data_q;

  assign en = !out_vld_q || !out_stall_i;

  sem_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .win_o       (win)
  );

  sem_grad u_grad (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .win_i  (win),
    .sq_o   (sq)
  );

  sem_root u_root (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .sq_i   (sq),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= res.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= res.data;
    end
  end

  assign in_stall_o  = !en;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_data_q;

endmodule
